/* rtl/lesf_pkg.sv */
// ============================================================================
// lesf_pkg
// Shared types and constants for the largest empty square finder.
// ============================================================================
`default_nettype none

package lesf_pkg;

   // Character width of one grid cell
   localparam int CHAR_W = 8;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd2;

   // Reset value of the obstacle character ('o')
   localparam logic [CHAR_W-1:0] OBSTACLE_RESET = 8'd111;

   // Depth of the decoupling queues and width of their fill counts
   localparam int Q_DEPTH = 2;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Classification of one cell, made by the front end
   typedef struct packed {
      logic is_obstacle; // cell matches the obstacle character
      logic is_edge;     // first row or first column: size is 1 unless it is an obstacle
      logic row_end;     // last cell of its row
      logic grid_end;    // last cell of the grid: a result beat follows
   } cell_flags_type;

   localparam int FLAGS_W = $bits(cell_flags_type);

endpackage : lesf_pkg

`default_nettype wire

/* rtl/lesf_fifo.sv */
// ============================================================================
// lesf_fifo
// Small register queue with a fill count, used between the front and back
// ends and in front of the result port.
// ============================================================================
`default_nettype none

module lesf_fifo
   import lesf_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire logic [WIDTH-1:0]   push_data,
   input  wire logic               pop,
   output logic      [WIDTH-1:0]   head_data,
   output logic      [Q_CNT_W-1:0] count
);

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

   logic [WIDTH-1:0]   slot_ff [Q_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule : lesf_fifo

`default_nettype wire

/* rtl/lesf_front.sv */
// ============================================================================
// lesf_front
// Front end: configuration registers, row/column scan counters and the
// classification of each accepted cell.
// ============================================================================
`default_nettype none

module lesf_front
   import lesf_pkg::*;
#(
   parameter int MAX_ROWS = 4096,
   parameter int MAX_COLS = 1024,
   parameter int RW       = 12,
   parameter int CW       = 10,
   parameter int DW       = 13
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration writes
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DW-1:0]        csr_wdata,
   // accepted cell
   input  wire logic                 accept,
   input  wire logic [CHAR_W-1:0]    cell_char,
   // classification of the current cell
   output cell_flags_type            flags,
   output logic      [RW-1:0]        row,
   output logic      [CW-1:0]        col
);

   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int CCW = $clog2(MAX_COLS + 1);

   logic [CHAR_W-1:0] obstacle_ff;
   logic [RCW-1:0]    grid_rows_ff;
   logic [CCW-1:0]    grid_cols_ff;
   logic [RW-1:0]     row_count_ff, row_count_in;
   logic [CW-1:0]     col_count_ff, col_count_in;

   logic [RCW-1:0]    rows_eff;
   logic [CCW-1:0]    cols_eff;
   logic              row_end;
   logic              grid_end;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         obstacle_ff  <= OBSTACLE_RESET;
         grid_rows_ff <= RCW'(1);
         grid_cols_ff <= CCW'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_OBSTACLE:  obstacle_ff  <= csr_wdata[CHAR_W-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[RCW-1:0];
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata[CCW-1:0];
            default: ;
         endcase
      end
   end

   // Dimensions: zero acts as one, oversize saturates
   always_comb begin
      if (grid_rows_ff == '0) begin
         rows_eff = RCW'(1);
      end else if (grid_rows_ff > RCW'(MAX_ROWS)) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = grid_rows_ff;
      end
      if (grid_cols_ff == '0) begin
         cols_eff = CCW'(1);
      end else if (grid_cols_ff > CCW'(MAX_COLS)) begin
         cols_eff = CCW'(MAX_COLS);
      end else begin
         cols_eff = grid_cols_ff;
      end
   end

   // Classification
   assign row_end  = ((CCW+1)'(col_count_ff) + 1'b1) >= (CCW+1)'(cols_eff);
   assign grid_end = row_end &&
                     (((RCW+1)'(row_count_ff) + 1'b1) >= (RCW+1)'(rows_eff));

   always_comb begin
      flags.is_obstacle = (cell_char == obstacle_ff);
      flags.is_edge     = (row_count_ff == '0) || (col_count_ff == '0);
      flags.row_end     = row_end;
      flags.grid_end    = grid_end;
   end

   assign row = row_count_ff;
   assign col = col_count_ff;

   // Scan counters
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (grid_end) begin
         row_count_in = '0;
         col_count_in = '0;
      end else if (row_end) begin
         row_count_in = RW'(row_count_ff + 1'b1);
         col_count_in = '0;
      end else begin
         col_count_in = CW'(col_count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else if (accept) begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

endmodule : lesf_front

`default_nettype wire

/* rtl/lesf_back.sv */
// ============================================================================
// lesf_back
// Back end: line buffer of square sizes, neighbour registers, the
// min-of-three update and best-square tracking.
// ============================================================================
`default_nettype none

module lesf_back
   import lesf_pkg::*;
#(
   parameter int MAX_COLS = 1024,
   parameter int RW       = 12,
   parameter int CW       = 10,
   parameter int SW       = 11
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // head of the cell queue
   input  wire logic               head_valid,
   input  wire cell_flags_type     head_flags,
   input  wire logic [RW-1:0]      head_row,
   input  wire logic [CW-1:0]      head_col,
   output logic                    head_pop,
   // result queue
   input  wire logic [Q_CNT_W-1:0] res_count,
   input  wire logic               res_pop,
   output logic                    res_push,
   output logic      [SW-1:0]      res_size,
   output logic      [RW-1:0]      res_row,
   output logic      [CW-1:0]      res_col
);

   // Line buffer
   logic [SW-1:0]  line_mem [MAX_COLS];

   // Execute stage
   logic           s_valid_ff;
   cell_flags_type s_flags_ff;
   logic [RW-1:0]  s_row_ff;
   logic [CW-1:0]  s_col_ff;
   logic [SW-1:0]  rdata_ff;
   logic           fwd_ff, fwd_in;
   logic [SW-1:0]  fwd_data_ff;

   // Neighbours and best so far
   logic [SW-1:0]  left_ff, left_in;
   logic [SW-1:0]  diag_ff, diag_in;
   logic [SW-1:0]  best_size_ff, best_size_in;
   logic [RW-1:0]  best_row_ff, best_row_in;
   logic [CW-1:0]  best_col_ff, best_col_in;

   logic [SW-1:0]  up;
   logic [SW-1:0]  min_ul;
   logic [SW-1:0]  min3;
   logic [SW-1:0]  size;
   logic           s_last;

   // Take a cell only when its result beat is sure to find room;
   // a beat leaving the result queue this cycle frees a slot
   assign s_last   = s_valid_ff && s_flags_ff.grid_end;
   assign head_pop = head_valid &&
                     (!head_flags.grid_end ||
                      (((Q_CNT_W+1)'(res_count) + (Q_CNT_W+1)'(s_last))
                        < ((Q_CNT_W+1)'(Q_DEPTH) + (Q_CNT_W+1)'(res_pop))));

   // Bypass a line-buffer entry written at the same edge it was read
   assign fwd_in = head_pop && s_valid_ff && (head_col == s_col_ff);
   assign up     = fwd_ff ? fwd_data_ff : rdata_ff;

   // Size of the current cell
   always_comb begin
      min_ul = (up < left_ff) ? up : left_ff;
      min3   = (diag_ff < min_ul) ? diag_ff : min_ul;
      if (s_flags_ff.is_obstacle) begin
         size = '0;
      end else if (s_flags_ff.is_edge) begin
         size = SW'(1);
      end else begin
         size = SW'(min3 + 1'b1);
      end
   end

   // Neighbour and best update
   always_comb begin
      left_in      = left_ff;
      diag_in      = diag_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      res_size     = best_size_ff;
      res_row      = best_row_ff;
      res_col      = best_col_ff;
      if (s_valid_ff) begin
         left_in = size;
         diag_in = up;
         if (size > best_size_ff) begin
            best_size_in = size;
            best_row_in  = s_row_ff;
            best_col_in  = s_col_ff;
         end
         res_size = best_size_in;
         res_row  = best_row_in;
         res_col  = best_col_in;
         if (s_flags_ff.grid_end) begin
            left_in      = '0;
            diag_in      = '0;
            best_size_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end else if (s_flags_ff.row_end) begin
            left_in = '0;
            diag_in = '0;
         end
      end
   end

   assign res_push = s_last;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         left_ff      <= '0;
         diag_ff      <= '0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
      end else begin
         s_valid_ff   <= head_pop;
         fwd_ff       <= fwd_in;
         left_ff      <= left_in;
         diag_ff      <= diag_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
      end
   end

   // Stage payload and line buffer
   always_ff @(posedge clock) begin
      if (head_pop) begin
         s_flags_ff <= head_flags;
         s_row_ff   <= head_row;
         s_col_ff   <= head_col;
         rdata_ff   <= line_mem[head_col];
      end
      if (s_valid_ff) begin
         line_mem[s_col_ff] <= size;
      end
      fwd_data_ff <= size;
   end

   // Checks
   a_res_room: assert property (@(posedge clock) disable iff (reset)
      s_last |-> (res_count < Q_CNT_W'(Q_DEPTH)))
      else $error("result beat pushed into a full queue");

   a_fwd_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s_valid_ff)
      else $error("bypass active without a cell in the stage");

   a_best_clear: assert property (@(posedge clock) disable iff (reset)
      s_last |=> (best_size_ff == '0 && left_ff == '0 && diag_ff == '0))
      else $error("scan state not cleared after grid end");

   a_obstacle_left: assert property (@(posedge clock) disable iff (reset)
      (s_valid_ff && s_flags_ff.is_obstacle) |=> (left_ff == '0))
      else $error("obstacle cell left a non-zero size");

endmodule : lesf_back

`default_nettype wire

/* rtl/largest_empty_square_finder_core.sv */
// ============================================================================
// largest_empty_square_finder_core
// Streams a character grid in row-major order and reports the largest square
// free of obstacles, with its bottom-right corner, after the last cell.
// ============================================================================
//
//  channel | ports                              | direction | handshake
//  --------+------------------------------------+-----------+-------------------
//  req     | req_cell_char                      | in        | push / full
//  rsp     | rsp_best_size/_row/_col            | out       | empty / pop
//  csr     | csr_index, csr_wdata               | in        | csr_write_en
//
//  One cell per cycle sustained; the result reaches the rsp ports through the
//  cell queue, the execute stage and the result queue once the grid's last cell is accepted.
//  The limit is the single line-buffer port pair: one read and one write a cycle.
//  Reset is synchronous; the line buffer is not cleared and needs no sweep.
//  A full result queue stalls the back end only for a grid-end cell; cells
//  keep queueing at the front until the two-deep cell queue fills.
// ============================================================================
`default_nettype none

module largest_empty_square_finder_core
   import lesf_pkg::*;
#(
   parameter  int MAX_COLS = 1024,
   parameter  int MAX_ROWS = 4096,
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int SW  = $clog2(MAX_COLS + 1),
   localparam int RCW = $clog2(MAX_ROWS + 1),
   localparam int CCW = $clog2(MAX_COLS + 1),
   localparam int DW  = (RCW > CCW) ? ((RCW > CHAR_W) ? RCW : CHAR_W)
                                    : ((CCW > CHAR_W) ? CCW : CHAR_W)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // cell input
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [CHAR_W-1:0]    req_cell_char,
   // result output
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [SW-1:0]             rsp_best_size,
   output logic [RW-1:0]             rsp_best_row,
   output logic [CW-1:0]             rsp_best_col,
   // configuration
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DW-1:0]        csr_wdata
);

   localparam int MQ_W  = FLAGS_W + RW + CW;
   localparam int RES_W = SW + RW + CW;

   logic                 accept;
   cell_flags_type       front_flags;
   logic [RW-1:0]        front_row;
   logic [CW-1:0]        front_col;

   logic [MQ_W-1:0]      mq_head;
   logic [Q_CNT_W-1:0]   mq_count;
   logic                 mq_pop;
   cell_flags_type       head_flags;
   logic [RW-1:0]        head_row;
   logic [CW-1:0]        head_col;

   logic                 res_push;
   logic [SW-1:0]        res_size;
   logic [RW-1:0]        res_row;
   logic [CW-1:0]        res_col;
   logic [RES_W-1:0]     rq_head;
   logic [Q_CNT_W-1:0]   rq_count;
   logic                 rsp_accept;

   // Input handshake
   assign req_full = (mq_count == Q_CNT_W'(Q_DEPTH));
   assign accept   = req_push && !req_full;

   lesf_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .RW       (RW),
      .CW       (CW),
      .DW       (DW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .cell_char    (req_cell_char),
      .flags        (front_flags),
      .row          (front_row),
      .col          (front_col)
   );

   // Cell queue between front and back
   lesf_fifo #(
      .WIDTH (MQ_W)
   ) u_cell_q (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({front_flags, front_row, front_col}),
      .pop       (mq_pop),
      .head_data (mq_head),
      .count     (mq_count)
   );

   assign head_flags = cell_flags_type'(mq_head[MQ_W-1 -: FLAGS_W]);
   assign head_row   = mq_head[CW +: RW];
   assign head_col   = mq_head[CW-1:0];

   lesf_back #(
      .MAX_COLS (MAX_COLS),
      .RW       (RW),
      .CW       (CW),
      .SW       (SW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (mq_count != '0),
      .head_flags (head_flags),
      .head_row   (head_row),
      .head_col   (head_col),
      .head_pop   (mq_pop),
      .res_count  (rq_count),
      .res_pop    (rsp_accept),
      .res_push   (res_push),
      .res_size   (res_size),
      .res_row    (res_row),
      .res_col    (res_col)
   );

   // Result queue
   assign rsp_accept = rsp_pop && !rsp_empty;

   lesf_fifo #(
      .WIDTH (RES_W)
   ) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data ({res_size, res_row, res_col}),
      .pop       (rsp_accept),
      .head_data (rq_head),
      .count     (rq_count)
   );

   assign rsp_empty     = (rq_count == '0);
   assign rsp_best_size = rq_head[RES_W-1 -: SW];
   assign rsp_best_row  = rq_head[CW +: RW];
   assign rsp_best_col  = rq_head[CW-1:0];

endmodule : largest_empty_square_finder_core

`default_nettype wire

/* test/lesf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_checker
// Watches the cell, result and register ports of the square finder, keeps its
// own scan of the grid and checks every result beat against it.
// ----------------------------------------------------------------------------

module lesf_checker
   import lesf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic                 req_full,
   input  wire logic [CHAR_W-1:0]    req_cell_char,
   input  wire logic                 rsp_empty,
   input  wire logic                 rsp_pop,
   input  wire logic [10:0]          rsp_best_size,
   input  wire logic [11:0]          rsp_best_row,
   input  wire logic [9:0]           rsp_best_col,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [12:0]          csr_wdata,
   output int                        fail_count,
   output int                        results_due
);

   localparam int LINE_DEPTH = 1024;
   localparam int ROW_LIMIT  = 4096;

   typedef struct packed {
      logic [10:0] size;
      logic [11:0] row;
      logic [9:0]  col;
   } square_type;

   // register copies
   logic [CHAR_W-1:0] obstacle;
   logic [12:0]       rows_setting;
   logic [10:0]       cols_setting;

   // scan state
   logic [10:0] line_sizes [LINE_DEPTH];
   logic [10:0] left_size, diag_size, best_size;
   logic [11:0] row_idx, best_row;
   logic [9:0]  col_idx, best_col;

   square_type squares_due[$];

   // zero acts as one, oversized values saturate
   function automatic int unsigned span(input int unsigned v, input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   task automatic clear_scan();
      left_size = '0;
      diag_size = '0;
      row_idx   = '0;
      col_idx   = '0;
      best_size = '0;
      best_row  = '0;
      best_col  = '0;
   endtask

   task automatic flag_error(input string msg);
      $display("%0t lesf_checker: %s", $time, msg);
      fail_count++;
   endtask

   // one accepted cell: size of the square ending here, best tracking, grid end
   task automatic scan_cell(input logic [CHAR_W-1:0] ch);
      logic [10:0] up, size, least;
      logic        row_end, grid_end;
      square_type  sq;
      up = line_sizes[col_idx];
      if (ch == obstacle) begin
         size = '0;
      end else if (row_idx == 0 || col_idx == 0) begin
         size = 11'd1;
      end else begin
         least = up;
         if (left_size < least) least = left_size;
         if (diag_size < least) least = diag_size;
         size = least + 11'd1;
      end
      line_sizes[col_idx] = size;
      left_size = size;
      diag_size = up;

      // first strictly larger square wins
      if (size > best_size) begin
         best_size = size;
         best_row  = row_idx;
         best_col  = col_idx;
      end

      row_end  = (int'(col_idx) + 1 >= span(cols_setting, LINE_DEPTH));
      grid_end = row_end && (int'(row_idx) + 1 >= span(rows_setting, ROW_LIMIT));
      if (grid_end) begin
         sq.size = best_size;
         sq.row  = best_row;
         sq.col  = best_col;
         squares_due.push_back(sq);
         clear_scan();
      end else if (row_end) begin
         col_idx   = '0;
         row_idx   = row_idx + 12'd1;
         left_size = '0;
         diag_size = '0;
      end else begin
         col_idx = col_idx + 10'd1;
      end
   endtask

   // one result beat against the oldest square due
   task automatic check_square();
      square_type want;
      if (squares_due.size() == 0) begin
         flag_error($sformatf("result beat with nothing due: size %0d row %0d col %0d",
                              rsp_best_size, rsp_best_row, rsp_best_col));
      end else begin
         want = squares_due.pop_front();
         if (rsp_best_size !== want.size)
            flag_error($sformatf("best_size %0d, want %0d", rsp_best_size, want.size));
         if (rsp_best_row !== want.row)
            flag_error($sformatf("best_row %0d, want %0d", rsp_best_row, want.row));
         if (rsp_best_col !== want.col)
            flag_error($sformatf("best_col %0d, want %0d", rsp_best_col, want.col));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         obstacle     = OBSTACLE_RESET;
         rows_setting = 13'd1;
         cols_setting = 11'd1;
         foreach (line_sizes[i]) line_sizes[i] = '0;
         clear_scan();
         squares_due.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_OBSTACLE:  obstacle     = csr_wdata[CHAR_W-1:0];
               CSR_GRID_ROWS: rows_setting = csr_wdata;
               CSR_GRID_COLS: cols_setting = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) scan_cell(req_cell_char);
         if (rsp_pop && !rsp_empty) check_square();
      end
      results_due <= squares_due.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams grids of characters into the square finder: a few hand-made grids,
// then random grids with register changes between and inside them, and one
// grid at the widest row. The checker predicts and compares each result.
// ----------------------------------------------------------------------------

module tb_top;
   import lesf_pkg::*;

   localparam int RANDOM_CELLS = 700;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [CHAR_W-1:0]    req_cell_char;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic [10:0]          rsp_best_size;
   logic [11:0]          rsp_best_row;
   logic [9:0]           rsp_best_col;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [12:0]          csr_wdata;
   int                   fail_count;
   int                   results_due;

   // stimulus bookkeeping
   int                push_gap_pct;
   int                pop_stall_pct;
   int                cells_sent;
   int                cycle_count;
   logic [CHAR_W-1:0] cur_obstacle;
   int unsigned       rows_eff;
   int unsigned       cols_eff;

   largest_empty_square_finder_core DUT (.*);
   lesf_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run guard
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // result side: random stalls
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   function automatic int unsigned span(input int unsigned v, input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic logic [CHAR_W-1:0] draw_char(input int obst_pct);
      if ($urandom_range(99) < obst_pct) return cur_obstacle;
      return CHAR_W'($urandom_range(255));
   endfunction

   // one cell beat; push stays high after acceptance for the next caller
   task automatic push_cell(input logic [CHAR_W-1:0] ch);
      while ($urandom_range(99) < push_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_cell_char <= ch;
      do @(posedge clock); while (req_full);
      cells_sent++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_cell(s[i]);
   endtask

   // hold off until every result is out and the pipeline has emptied
   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_grid(input logic [CHAR_W-1:0] obst, input logic [12:0] rows,
                               input logic [10:0] cols);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_OBSTACLE;
      csr_wdata    <= 13'(obst);
      @(posedge clock);
      csr_index    <= CSR_GRID_ROWS;
      csr_wdata    <= rows;
      @(posedge clock);
      csr_index    <= CSR_GRID_COLS;
      csr_wdata    <= 13'(cols);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_obstacle = obst;
      rows_eff     = span(rows, 4096);
      cols_eff     = span(cols, 1024);
   endtask

   // One whole grid. A change inside the grid happens from the second row on
   // and never widens the rows, so every line buffer read was written here.
   task automatic stream_grid(input int obst_pct, input bit mid_change, input bit last_free);
      int unsigned       r, c;
      int                n, change_at;
      bit                done, row_end, last_cell;
      logic [CHAR_W-1:0] ch;
      r = 0;
      c = 0;
      n = 0;
      done = 1'b0;
      change_at = -1;
      if (mid_change && rows_eff > 1)
         change_at = $urandom_range(rows_eff * cols_eff - 1, cols_eff);
      while (!done) begin
         if (n == change_at && r >= 1) begin
            drain_results();
            program_grid(CHAR_W'($urandom_range(255)), 13'($urandom_range(r + 3, 0)),
                         11'($urandom_range(cols_eff, 0)));
         end
         row_end   = (c + 1 >= cols_eff);
         last_cell = row_end && (r + 1 >= rows_eff);
         ch = (last_cell && last_free) ? (cur_obstacle ^ 8'h01) : draw_char(obst_pct);
         push_cell(ch);
         n++;
         if (last_cell) begin
            done = 1'b1;
         end else if (row_end) begin
            c = 0;
            r++;
         end else begin
            c++;
         end
      end
   endtask

   initial begin
      int base, pct;
      logic [12:0] rows;
      logic [10:0] cols;
      req_push      <= 1'b0;
      req_cell_char <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_OBSTACLE;
      csr_wdata     <= '0;
      reset         <= 1'b1;
      push_gap_pct  = 10;
      pop_stall_pct = 58;
      cells_sent    = 0;
      cur_obstacle  = OBSTACLE_RESET;
      rows_eff      = 1;
      cols_eff      = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 1x1 grid, obstacle 'o'
      push_cell(OBSTACLE_RESET);
      push_cell(8'h00);
      drain_results();

      // zero sizes act as one
      program_grid(8'h00, 13'd0, 11'd0);
      push_cell(8'h00);
      push_cell(8'hFF);
      drain_results();

      // fully free 3x3 grid
      program_grid(8'hFF, 13'd3, 11'd3);
      push_text({"a\177a", "\177a\177", "a\177a"});
      drain_results();

      // nothing but obstacles
      program_grid(8'h80, 13'd1, 11'd3);
      push_text("\200\200\200");
      drain_results();

      // two equal squares: the first one found wins
      program_grid("#", 13'd2, 11'd5);
      push_text({"..#..", "..#.."});

      // random grids, idling shifted between the two sides
      base = cells_sent;
      while (cells_sent - base < RANDOM_CELLS) begin
         if (cells_sent - base < RANDOM_CELLS / 3) begin
            push_gap_pct  = 10;
            pop_stall_pct = 58;
         end else if (cells_sent - base < 2 * RANDOM_CELLS / 3) begin
            push_gap_pct  = 58;
            pop_stall_pct = 10;
         end else begin
            push_gap_pct  = 0;
            pop_stall_pct = 0;
         end
         // about half the grids follow on back to back with the same settings
         if ($urandom_range(1) == 0) begin
            rows = ($urandom_range(15) == 0) ? 13'd0 : 13'($urandom_range(8, 1));
            case ($urandom_range(15))
               0:       cols = 11'd0;
               1, 2:    cols = 11'($urandom_range(48, 13));
               default: cols = 11'($urandom_range(12, 1));
            endcase
            drain_results();
            program_grid(CHAR_W'($urandom_range(255)), rows, cols);
         end
         case ($urandom_range(5))
            0:       pct = 0;
            1:       pct = 10;
            2:       pct = 25;
            3:       pct = 50;
            4:       pct = 90;
            default: pct = 100;
         endcase
         stream_grid(pct, ($urandom_range(2) == 0), 1'b0);
      end

      // widest row, with the column count saturating
      push_gap_pct  = 0;
      pop_stall_pct = 0;
      drain_results();
      program_grid(CHAR_W'($urandom_range(255)), 13'd1, 11'd2047);
      stream_grid(100, 1'b0, 1'b1);

      drain_results();
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
